### rtl/knn_sel_pkg.sv
// Shared types and constants of the k-nearest-neighbor class selector.
// No dependencies; imported by the divider, the top level, the monitor and the testbench.
`timescale 1ns / 1ps

package knn_sel_pkg;

	// fixed widths of the interface fields
	localparam int CLASS_W    = 4;
	localparam int SCORE_W    = 35;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AGG_MODE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 2'd1;

	// reset values of the configuration registers
	localparam logic                  AGG_MODE_RESET = 1'b0;
	localparam logic [CFG_DATA_W-1:0] K_RESET        = 4'd3;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SHIFT,
		ST_ACC,
		ST_CLS,
		ST_DIV,
		ST_EMIT
	} knn_state_t;

endpackage

### rtl/knn_sel_div.sv
// Restoring divider, one quotient bit per cycle, for the per-class mean.
// Depends on knn_sel_pkg (imported for house consistency).
`timescale 1ns / 1ps

module knn_sel_div #(
	parameter int SW = 36,
	parameter int CW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [SW-1:0] dividend,
	input  logic [CW-1:0] divisor,
	output logic          done,
	output logic [SW-1:0] quotient
);
	import knn_sel_pkg::*;

	localparam int STW = $clog2(SW + 1);

	logic [CW-1:0]  rem_q;
	logic [SW-1:0]  quo_q;
	logic [CW-1:0]  dvs_q;
	logic [STW-1:0] step_q;
	logic           run_q;
	logic           done_q;

	logic [CW:0]    shifted;
	logic [CW:0]    diff;

	// trial subtract of the divisor from the shifted remainder
	assign shifted = {rem_q, quo_q[SW-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	// iterate over all dividend bits, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
			end else if (run_q) begin
				if (!diff[CW]) begin
					rem_q <= diff[CW-1:0];
					quo_q <= {quo_q[SW-2:0], 1'b1};
				end else begin
					rem_q <= shifted[CW-1:0];
					quo_q <= {quo_q[SW-2:0], 1'b0};
				end
				if (step_q == STW'(SW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/knn_class_selector.sv
// K-nearest-neighbor class selector: sorted keep list, per-class vote, winner out.
// Sequence: after the accept edge busy stays high for a tail check when the list is
// full, then one shift per cycle; a sample with an out-of-range class that is not last frees
// the block at once. On the last sample add the accumulate walk over the kept entries, the
// sweep over every class, a divide per voted class in mean mode, and the result, shown for one cycle.
// Flow: a new sample is taken in any cycle in which busy is low; results cannot be stalled.
// Reset clears the keep count, per-class sums, registers and sequencer; list entries hold none.
`timescale 1ns / 1ps

module knn_class_selector #(
	parameter int MAX_K       = 8,
	parameter int NUM_CLASSES = 16,
	parameter int DIST_BITS   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic [31:0]                          distance,
	input  logic [knn_sel_pkg::CLASS_W-1:0]      class_id,
	input  logic                                 last,
	// configuration channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [knn_sel_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [knn_sel_pkg::CFG_DATA_W-1:0]   cfg_data,
	// result
	output logic                                 result_valid,
	output logic [knn_sel_pkg::CLASS_W-1:0]      best_class,
	output logic                                 found,
	output logic [knn_sel_pkg::SCORE_W-1:0]      best_score
);
	import knn_sel_pkg::*;

	localparam int KCW = $clog2(MAX_K + 1);
	localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int KXW = (KCW > CFG_DATA_W) ? KCW : CFG_DATA_W;
	localparam int NCE = (NUM_CLASSES < 16) ? NUM_CLASSES : 16;
	localparam int CIW = $clog2(NCE);
	localparam int SW  = DIST_BITS + KCW;
	localparam int SXW = (SW > SCORE_W) ? SW : SCORE_W;

	knn_state_t state_q, state_d;

	// configuration
	logic                  agg_mode_q;
	logic [CFG_DATA_W-1:0] neighbor_q;

	// keep list, no reset: only entries below the fill are read
	logic [DIST_BITS-1:0] kept_dist_q [MAX_K];
	logic [CLASS_W-1:0]   kept_cls_q  [MAX_K];
	logic [KCW-1:0]       fill_q;

	// latched sample
	logic [DIST_BITS-1:0] d_q;
	logic [CLASS_W-1:0]   c_q;
	logic                 last_q;

	// walk counters
	logic [KIW-1:0] j_q;
	logic [KCW-1:0] i_q;
	logic [CIW-1:0] cls_q;

	// per-class accumulators
	logic [SW-1:0]  sum_q [NCE];
	logic [KCW-1:0] cnt_q [NCE];

	// running winner
	logic           have_q;
	logic [SW-1:0]  best_q;
	logic [CIW-1:0] best_cls_q;

	// combinational helpers
	logic [KCW-1:0]       k_eff;
	logic [KXW-1:0]       nc_x;
	logic [KCW-1:0]       fill_c;
	logic                 accept;
	logic                 in_cls_ok;
	logic [KIW-1:0]       rd_idx;
	logic [DIST_BITS-1:0] rd_dist;
	logic [CLASS_W-1:0]   rd_cls;
	logic                 goes_before;
	logic                 place;
	logic                 last_cls;
	logic [SW-1:0]        cand;
	logic                 cand_wins;
	logic [CIW-1:0]       acc_cls;
	logic                 div_start;
	logic                 div_done;
	logic [SW-1:0]        div_quo;
	logic [SXW-1:0]       best_x;

	// clamp K to 1..MAX_K
	assign nc_x = KXW'(neighbor_q);
	always_comb begin
		if (nc_x == '0) begin
			k_eff = KCW'(1);
		end else if (nc_x > KXW'(MAX_K)) begin
			k_eff = KCW'(MAX_K);
		end else begin
			k_eff = KCW'(nc_x);
		end
	end

	assign fill_c    = (fill_q > k_eff) ? k_eff : fill_q;
	assign accept    = start && !busy;
	assign in_cls_ok = {5'd0, class_id} < 9'(NUM_CLASSES);

	// single list read port: compare walk or accumulate walk
	always_comb begin
		case (state_q)
			ST_ACC:   rd_idx = i_q[KIW-1:0];
			ST_CHECK: rd_idx = j_q;
			default:  rd_idx = j_q - 1'b1;
		endcase
	end
	assign rd_dist = kept_dist_q[rd_idx];
	assign rd_cls  = kept_cls_q[rd_idx];

	// shared order compare: sample strictly ahead of the entry read
	assign goes_before = (d_q != rd_dist) ? (d_q < rd_dist) : (c_q < rd_cls);
	assign place       = (j_q == '0) || !goes_before;

	assign acc_cls   = rd_cls[CIW-1:0];
	assign last_cls  = (cls_q == CIW'(NCE - 1));
	assign cand      = (state_q == ST_DIV) ? div_quo : sum_q[cls_q];
	assign cand_wins = !have_q || (cand < best_q);

	knn_sel_div #(
		.SW (SW),
		.CW (KCW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[cls_q]),
		.divisor  (cnt_q[cls_q]),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_cls_ok) begin
						state_d = (fill_c < k_eff) ? ST_SHIFT : ST_CHECK;
					end else if (last) begin
						state_d = ST_ACC;
					end
				end
			end
			ST_CHECK: begin
				if (goes_before) begin
					state_d = ST_SHIFT;
				end else begin
					state_d = last_q ? ST_ACC : ST_IDLE;
				end
			end
			ST_SHIFT: begin
				if (place) begin
					state_d = last_q ? ST_ACC : ST_IDLE;
				end
			end
			ST_ACC: begin
				if (i_q == fill_c) begin
					state_d = ST_CLS;
				end
			end
			ST_CLS: begin
				if ((cnt_q[cls_q] == '0) || agg_mode_q) begin
					state_d = last_cls ? ST_EMIT : ST_CLS;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = last_cls ? ST_EMIT : ST_CLS;
				end
			end
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy         = (state_q != ST_IDLE);
		result_valid = (state_q == ST_EMIT);
		div_start    = (state_q == ST_CLS) && (cnt_q[cls_q] != '0) && !agg_mode_q;
	end

	assign cfg_ready = 1'b1;

	// hold configuration words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agg_mode_q <= AGG_MODE_RESET;
			neighbor_q <= K_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_AGG_MODE:       agg_mode_q <= cfg_data[0];
				CFG_NEIGHBOR_COUNT: neighbor_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	// shift the list up one entry per cycle, drop the sample into its slot
	always_ff @(posedge clk) begin
		if (state_q == ST_SHIFT) begin
			if (place) begin
				kept_dist_q[j_q] <= d_q;
				kept_cls_q[j_q]  <= c_q;
			end else begin
				kept_dist_q[j_q] <= rd_dist;
				kept_cls_q[j_q]  <= rd_cls;
			end
		end
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			d_q        <= '0;
			c_q        <= '0;
			last_q     <= 1'b0;
			j_q        <= '0;
			i_q        <= '0;
			cls_q      <= '0;
			have_q     <= 1'b0;
			best_q     <= '0;
			best_cls_q <= '0;
			for (int n = 0; n < NCE; n++) begin
				sum_q[n] <= '0;
				cnt_q[n] <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						d_q    <= DIST_BITS'(distance);
						c_q    <= class_id;
						last_q <= last;
						i_q    <= '0;
						cls_q  <= '0;
						have_q <= 1'b0;
						if (in_cls_ok) begin
							if (fill_c < k_eff) begin
								j_q    <= KIW'(fill_c);
								fill_q <= fill_c + 1'b1;
							end else begin
								j_q    <= KIW'(k_eff - 1'b1);
								fill_q <= fill_c;
							end
						end
					end
				end
				ST_SHIFT: begin
					if (!place) begin
						j_q <= j_q - 1'b1;
					end
				end
				ST_ACC: begin
					// add each kept entry into its class
					if (i_q != fill_c) begin
						sum_q[acc_cls] <= sum_q[acc_cls] + SW'(rd_dist);
						cnt_q[acc_cls] <= cnt_q[acc_cls] + 1'b1;
						i_q            <= i_q + 1'b1;
					end
				end
				ST_CLS: begin
					// read out and clear one class per cycle, save while a mean divide runs
					sum_q[cls_q] <= '0;
					cnt_q[cls_q] <= '0;
					if (cnt_q[cls_q] == '0) begin
						cls_q <= cls_q + 1'b1;
					end else if (agg_mode_q) begin
						if (cand_wins) begin
							have_q     <= 1'b1;
							best_q     <= cand;
							best_cls_q <= cls_q;
						end
						cls_q <= cls_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (cand_wins) begin
							have_q     <= 1'b1;
							best_q     <= cand;
							best_cls_q <= cls_q;
						end
						cls_q <= cls_q + 1'b1;
					end
				end
				ST_EMIT: fill_q <= '0;
				default: ;
			endcase
		end
	end

	// saturate the winning score into the result word
	assign best_x     = SXW'(best_q);
	assign found      = have_q;
	assign best_class = have_q ? CLASS_W'(best_cls_q) : '0;
	always_comb begin
		if (!have_q) begin
			best_score = '0;
		end else if (best_x > SXW'(SCORE_MAX)) begin
			best_score = SCORE_MAX;
		end else begin
			best_score = best_x[SCORE_W-1:0];
		end
	end

	// checks
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> (fill_q == '0))
		else $error("keep list not cleared after result");

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide step");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= KCW'(MAX_K))
		else $error("keep count above list depth");

	a_drop_free: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_cls_ok && !last) |=> !busy)
		else $error("dropped sample held the block busy");

endmodule

### test/knn_vote_monitor.sv
// Scoreboard for the k-nearest-neighbor class selector: watches the sample, register
// and result channels, predicts each vote from its own keep list and compares it.
// Depends on knn_sel_pkg for field widths, register indexes and reset values.
`timescale 1ns / 1ps

module knn_vote_monitor #(
	parameter int MAX_K       = 8,
	parameter int NUM_CLASSES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [31:0]                        distance,
	input  logic [knn_sel_pkg::CLASS_W-1:0]    class_id,
	input  logic                               last,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [knn_sel_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [knn_sel_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                               result_valid,
	input  logic [knn_sel_pkg::CLASS_W-1:0]    best_class,
	input  logic                               found,
	input  logic [knn_sel_pkg::SCORE_W-1:0]    best_score,
	output int unsigned                        fail_count,
	output int unsigned                        pending
);
	import knn_sel_pkg::*;

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic               hit;
		logic [SCORE_W-1:0] score;
	} vote_t;

	// shadow keep list and register copies
	logic [31:0]           near_dist [MAX_K];
	logic [CLASS_W-1:0]    near_cls  [MAX_K];
	int unsigned           near_fill;
	logic                  mode_q;
	logic [CFG_DATA_W-1:0] k_q;
	vote_t                 votes_due [$];

	// out-of-range K folds into 1..MAX_K
	function automatic int unsigned clamp_k(input logic [CFG_DATA_W-1:0] kv);
		if (kv < 1) return 1;
		if (kv > MAX_K) return MAX_K;
		return kv;
	endfunction

	// strict order: lower distance first, then lower class id
	function automatic bit orders_ahead(input logic [31:0] d, input logic [CLASS_W-1:0] c,
			input int unsigned i);
		if (d != near_dist[i]) return d < near_dist[i];
		return c < near_cls[i];
	endfunction

	// insert one sample into the sorted list, dropping the tail when full
	function automatic void keep_sample(input logic [31:0] d, input logic [CLASS_W-1:0] c);
		int unsigned k;
		int unsigned pos;
		int unsigned j;
		k = clamp_k(k_q);
		// cut the list when K was lowered since the last insert
		if (near_fill > k) near_fill = k;
		pos = 0;
		while (pos < near_fill && !orders_ahead(d, c, pos)) pos++;
		if (pos < k) begin
			j = (near_fill < k) ? near_fill : k - 1;
			while (j > pos) begin
				near_dist[j] = near_dist[j-1];
				near_cls[j]  = near_cls[j-1];
				j--;
			end
			near_dist[pos] = d;
			near_cls[pos]  = c;
			if (near_fill < k) near_fill++;
		end
	endfunction

	// per-class sum or mean over the kept entries, least score wins
	function automatic vote_t tally_vote();
		logic [63:0] sums [NUM_CLASSES];
		int unsigned cnts [NUM_CLASSES];
		int unsigned n;
		logic [63:0] score;
		logic [63:0] least;
		vote_t       v;
		foreach (sums[c]) begin
			sums[c] = '0;
			cnts[c] = 0;
		end
		n = near_fill;
		if (n > clamp_k(k_q)) n = clamp_k(k_q);
		for (int unsigned i = 0; i < n; i++) begin
			sums[near_cls[i]] += near_dist[i];
			cnts[near_cls[i]]++;
		end
		v     = '0;
		least = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (cnts[c] == 0) continue;
			score = mode_q ? sums[c] : sums[c] / cnts[c];
			if (!v.hit || score < least) begin
				v.hit = 1'b1;
				v.cls = CLASS_W'(c);
				least = score;
			end
		end
		// saturate the score at the port width
		if (least > SCORE_MAX) least = SCORE_MAX;
		v.score = least[SCORE_W-1:0];
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// compare results, track register writes, then predict from accepted words
	always @(posedge clk or negedge arst_n) begin : watch
		vote_t due;
		if (!arst_n) begin
			near_fill  = 0;
			mode_q     = AGG_MODE_RESET;
			k_q        = K_RESET;
			fail_count = 0;
			votes_due.delete();
		end else begin
			if (result_valid) begin
				if (votes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result class %0d found %0b score %0d",
						best_class, found, best_score));
				end else begin
					due = votes_due.pop_front();
					if (best_class !== due.cls)
						report_mismatch($sformatf("best_class %0d, predicted %0d",
							best_class, due.cls));
					if (found !== due.hit)
						report_mismatch($sformatf("found %0b, predicted %0b", found, due.hit));
					if (best_score !== due.score)
						report_mismatch($sformatf("best_score %0d, predicted %0d",
							best_score, due.score));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_AGG_MODE:       mode_q = cfg_data[0];
					CFG_NEIGHBOR_COUNT: k_q    = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				// drop samples whose class is out of range
				if (class_id < NUM_CLASSES) keep_sample(distance, class_id);
				// last word closes the query: vote, then clear the list
				if (last) begin
					votes_due = {votes_due, tally_vote()};
					near_fill = 0;
				end
			end
		end
		pending = votes_due.size();
	end

endmodule

### test/tb_knn_class_selector.sv
// Testbench top for the k-nearest-neighbor class selector: clock, reset, sample and
// register stimulus, verdict. Depends on knn_sel_pkg, knn_class_selector, knn_vote_monitor.
`timescale 1ns / 1ps

module tb_knn_class_selector;
	import knn_sel_pkg::*;

	localparam int DRAIN_CYCLES  = 16;
	localparam int SETTLE_CYCLES = 400;
	localparam int PHASES        = 20;
	localparam int PHASE_ITEMS   = 57;
	localparam int QUIET_PHASES  = 3;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [31:0]           distance;
	logic [CLASS_W-1:0]    class_id;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  result_valid;
	logic [CLASS_W-1:0]    best_class;
	logic                  found;
	logic [SCORE_W-1:0]    best_score;
	int unsigned           fail_count;
	int unsigned           pending;

	bit          gaps_on;
	int unsigned samples_sent;

	knn_class_selector DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.distance     (distance),
		.class_id     (class_id),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.best_class   (best_class),
		.found        (found),
		.best_score   (best_score)
	);

	knn_vote_monitor monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.distance     (distance),
		.class_id     (class_id),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.best_class   (best_class),
		.found        (found),
		.best_score   (best_score),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#40_000_000;
		$display("tb_knn_class_selector failed");
		$finish;
	end

	task automatic drop_start();
		@(negedge clk);
		start = 1'b0;
	endtask

	// present one sample word and hold it until the block takes it
	task automatic push_sample(input logic [31:0] d, input logic [CLASS_W-1:0] c,
			input logic l);
		@(negedge clk);
		start    = 1'b1;
		distance = d;
		class_id = c;
		last     = l;
		@(posedge clk);
		while (busy) @(posedge clk);
		samples_sent++;
	endtask

	// sometimes hold off the sender for a burst of cycles
	task automatic idle_burst();
		int n;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 17);
			drop_start();
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// hold the sender until every vote is out and the block has settled
	task automatic wait_quiet();
		drop_start();
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		if (gaps_on) repeat ($urandom_range(0, 17)) @(negedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// write both registers in random order; mode word carries random upper bits
	task automatic set_mode_k(input logic m, input logic [CFG_DATA_W-1:0] k);
		logic [CFG_DATA_W-2:0] pad;
		pad = (CFG_DATA_W-1)'($urandom());
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_AGG_MODE, {pad, m});
			write_reg(CFG_NEIGHBOR_COUNT, k);
		end else begin
			write_reg(CFG_NEIGHBOR_COUNT, k);
			write_reg(CFG_AGG_MODE, {pad, m});
		end
	endtask

	// narrow values for ties, near-full values for wide sums, or anything
	function automatic logic [31:0] rand_distance(input int unsigned flavor);
		case (flavor)
			0:       return $urandom_range(0, 7);
			1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	// one query of len words; close marks the final word as last
	task automatic random_query(input int unsigned len, input bit close);
		int unsigned flavor;
		int unsigned span;
		flavor = $urandom_range(0, 2);
		span   = $urandom_range(0, 1) ? 3 : 15;
		for (int unsigned i = 0; i < len; i++) begin
			idle_burst();
			push_sample(rand_distance(flavor), CLASS_W'($urandom_range(0, span)),
				close && (i == len - 1));
		end
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] k_pick;
		logic                  m_pick;
		int unsigned           len;
		int unsigned           base;
		start        = 1'b0;
		distance     = '0;
		class_id     = '0;
		last         = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_AGG_MODE;
		cfg_data     = '0;
		gaps_on      = 1'b0;
		samples_sent = 0;
		arst_n       = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: mean over K=3, equal distances ordered by class, duplicate kept
		push_sample(32'd5, 4'd2, 1'b0);
		push_sample(32'd3, 4'd1, 1'b0);
		push_sample(32'd3, 4'd0, 1'b0);
		push_sample(32'd3, 4'd0, 1'b0);
		push_sample(32'd9, 4'd4, 1'b1);
		wait_quiet();

		// plain nearest neighbor on the largest distance and top class
		set_mode_k(1'b1, 4'd1);
		push_sample(32'hFFFF_FFFF, 4'd15, 1'b1);
		wait_quiet();

		// equal sums across classes: lower class wins
		set_mode_k(1'b1, 4'd2);
		push_sample(32'd3, 4'd6, 1'b0);
		push_sample(32'd3, 4'd2, 1'b1);
		wait_quiet();

		// full list of largest distances: widest sum
		set_mode_k(1'b1, 4'd8);
		for (int i = 0; i < 8; i++) push_sample(32'hFFFF_FFFF, 4'd7, i == 7);
		wait_quiet();

		// partial query, then K lowered before the closing word
		set_mode_k(1'b0, 4'd8);
		for (int i = 0; i < 5; i++) push_sample(32'(10 * (i + 1)), CLASS_W'(i + 1), 1'b0);
		wait_quiet();
		set_mode_k(1'b0, 4'd2);
		push_sample(32'd25, 4'd3, 1'b1);
		wait_quiet();

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       k_pick = 4'd1;
				1:       k_pick = 4'd8;
				2:       k_pick = 4'd0;
				3:       k_pick = 4'd15;
				4:       k_pick = 4'd9;
				default: k_pick = CFG_DATA_W'($urandom_range(0, 15));
			endcase
			m_pick  = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
			gaps_on = (ph < PHASES - QUIET_PHASES) && ($urandom_range(0, 4) != 0);
			set_mode_k(m_pick, k_pick);
			base = samples_sent;
			while (samples_sent - base < PHASE_ITEMS) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 9);
				random_query(len, 1'b1);
			end
			// leave a query open now and then; the next setting picks it up
			if ($urandom_range(0, 2) == 0) random_query($urandom_range(1, 6), 1'b0);
			wait_quiet();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_knn_class_selector passed");
		else
			$display("tb_knn_class_selector failed");
		$finish;
	end

endmodule

### filelist.f
rtl/knn_sel_pkg.sv
rtl/knn_sel_div.sv
rtl/knn_class_selector.sv
test/knn_vote_monitor.sv
test/tb_knn_class_selector.sv
